// ----- sv/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

  // Default width of one color channel.
  localparam int DEFAULT_CHANNEL_BITS = 8;

  // Width of the hue field, enough for 0 to 359 degrees.
  localparam int HUE_BITS = 9;

  // Sector offsets and the degree scale of one sector.
  localparam int unsigned DEG_60  = 60;
  localparam int unsigned DEG_120 = 120;
  localparam int unsigned DEG_240 = 240;
  localparam int unsigned DEG_360 = 360;

  // Number of quotient bits the divider row produces. It must cover both the
  // saturation quotient (channel width) and the hue quotient (hue width).
  function automatic int quot_bits(input int channel_bits);
    return (channel_bits > HUE_BITS) ? channel_bits : HUE_BITS;
  endfunction

endpackage

// ----- sv/rgbhsv_if.sv -----
interface rgbhsv_pix_if #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::DEFAULT_CHANNEL_BITS
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgbhsv_hsv_if #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::DEFAULT_CHANNEL_BITS
);
  logic                             valid;
  logic                             ready;
  logic [rgbhsv_pkg::HUE_BITS-1:0]  hue_deg;
  logic [CHANNEL_BITS-1:0]          saturation;
  logic [CHANNEL_BITS-1:0]          brightness;

  modport source (output valid, hue_deg, saturation, brightness, input ready);
  modport sink   (input valid, hue_deg, saturation, brightness, output ready);
endinterface

// ----- sv/rgbhsv_prep.sv -----
module rgbhsv_prep #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::DEFAULT_CHANNEL_BITS,
  parameter int NUM_BITS     = CHANNEL_BITS + rgbhsv_pkg::HUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [NUM_BITS-1:0]     sat_num,
  output logic [CHANNEL_BITS-1:0] sat_div,
  output logic [NUM_BITS-1:0]     hue_num,
  output logic [CHANNEL_BITS-1:0] hue_div,
  output logic [CHANNEL_BITS-1:0] bright
);

  localparam int CB = CHANNEL_BITS;
  localparam int NW = NUM_BITS;

  logic                    valid_r;
  logic [NW-1:0]           sat_num_r, sat_num_nxt;
  logic [CB-1:0]           sat_div_r, sat_div_nxt;
  logic [NW-1:0]           hue_num_r, hue_num_nxt;
  logic [CB-1:0]           hue_div_r, hue_div_nxt;
  logic [CB-1:0]           bright_r;

  logic [CB-1:0] mx, mn, dl;
  logic [NW-1:0] rx, gx, bx, dx;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl = mx - mn;
    rx = NW'(red);
    gx = NW'(green);
    bx = NW'(blue);
    dx = NW'(dl);

    // Saturation: full scale times delta over max, by shift and subtract.
    if (mx == '0) begin
      sat_num_nxt = '0;
      sat_div_nxt = CB'(1);
    end else begin
      sat_num_nxt = (dx << CB) - dx;
      sat_div_nxt = mx;
    end

    // Hue numerator per sector, always non-negative, divided by delta later.
    if (dl == '0) begin
      hue_num_nxt = '0;
      hue_div_nxt = CB'(1);
    end else begin
      hue_div_nxt = dl;
      if (mx == red) begin
        if (green >= blue) begin
          hue_num_nxt = (gx - bx) * NW'(rgbhsv_pkg::DEG_60);
        end else begin
          hue_num_nxt = dx * NW'(rgbhsv_pkg::DEG_360) - (bx - gx) * NW'(rgbhsv_pkg::DEG_60);
        end
      end else if (mx == green) begin
        hue_num_nxt = dx * NW'(rgbhsv_pkg::DEG_120) + bx * NW'(rgbhsv_pkg::DEG_60)
                      - rx * NW'(rgbhsv_pkg::DEG_60);
      end else begin
        hue_num_nxt = dx * NW'(rgbhsv_pkg::DEG_240) + rx * NW'(rgbhsv_pkg::DEG_60)
                      - gx * NW'(rgbhsv_pkg::DEG_60);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sat_num_r <= sat_num_nxt;
      sat_div_r <= sat_div_nxt;
      hue_num_r <= hue_num_nxt;
      hue_div_r <= hue_div_nxt;
      bright_r  <= mx;
    end
  end

  assign dn_valid = valid_r;
  assign sat_num  = sat_num_r;
  assign sat_div  = sat_div_r;
  assign hue_num  = hue_num_r;
  assign hue_div  = hue_div_r;
  assign bright   = bright_r;

endmodule

// ----- sv/rgbhsv_div_cell.sv -----
module rgbhsv_div_cell #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::DEFAULT_CHANNEL_BITS,
  parameter int QUOT_BITS    = rgbhsv_pkg::HUE_BITS,
  parameter int NUM_BITS     = CHANNEL_BITS + QUOT_BITS,
  parameter int BIT_POS      = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [NUM_BITS-1:0]     sat_rem_i,
  input  logic [CHANNEL_BITS-1:0] sat_div_i,
  input  logic [QUOT_BITS-1:0]    sat_q_i,
  input  logic [NUM_BITS-1:0]     hue_rem_i,
  input  logic [CHANNEL_BITS-1:0] hue_div_i,
  input  logic [QUOT_BITS-1:0]    hue_q_i,
  input  logic [CHANNEL_BITS-1:0] bright_i,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [NUM_BITS-1:0]     sat_rem_o,
  output logic [CHANNEL_BITS-1:0] sat_div_o,
  output logic [QUOT_BITS-1:0]    sat_q_o,
  output logic [NUM_BITS-1:0]     hue_rem_o,
  output logic [CHANNEL_BITS-1:0] hue_div_o,
  output logic [QUOT_BITS-1:0]    hue_q_o,
  output logic [CHANNEL_BITS-1:0] bright_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int QB = QUOT_BITS;
  localparam int NW = NUM_BITS;

  logic          valid_r;
  logic [NW-1:0] sat_rem_r, sat_rem_nxt;
  logic [CB-1:0] sat_div_r;
  logic [QB-1:0] sat_q_r, sat_q_nxt;
  logic [NW-1:0] hue_rem_r, hue_rem_nxt;
  logic [CB-1:0] hue_div_r;
  logic [QB-1:0] hue_q_r, hue_q_nxt;
  logic [CB-1:0] bright_r;

  logic [NW-1:0] sat_trial, hue_trial;
  logic          sat_bit, hue_bit;

  // One restoring step for each of the two divisions at this quotient bit.
  always_comb begin
    sat_trial   = NW'(sat_div_i) << BIT_POS;
    hue_trial   = NW'(hue_div_i) << BIT_POS;
    sat_bit     = (sat_rem_i >= sat_trial);
    hue_bit     = (hue_rem_i >= hue_trial);
    sat_rem_nxt = sat_bit ? (sat_rem_i - sat_trial) : sat_rem_i;
    hue_rem_nxt = hue_bit ? (hue_rem_i - hue_trial) : hue_rem_i;
    sat_q_nxt   = {sat_q_i[QB-2:0], sat_bit};
    hue_q_nxt   = {hue_q_i[QB-2:0], hue_bit};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sat_rem_r <= sat_rem_nxt;
      sat_div_r <= sat_div_i;
      sat_q_r   <= sat_q_nxt;
      hue_rem_r <= hue_rem_nxt;
      hue_div_r <= hue_div_i;
      hue_q_r   <= hue_q_nxt;
      bright_r  <= bright_i;
    end
  end

  assign dn_valid  = valid_r;
  assign sat_rem_o = sat_rem_r;
  assign sat_div_o = sat_div_r;
  assign sat_q_o   = sat_q_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign hue_q_o   = hue_q_r;
  assign bright_o  = bright_r;

endmodule

// ----- sv/rgb_to_hsv_converter.sv -----
// RGB to HSV pixel converter.
// The in_px channel carries one pixel per transfer: red_in, green_in and
// blue_in, each CHANNEL_BITS wide and unsigned. The out_px channel returns one
// result per pixel, in order: hue_deg (whole degrees, 0 to 359), saturation
// (full scale times delta over max, rounded down) and brightness (the largest
// channel). Both channels use valid/ready; a transfer happens on a rising edge
// with valid and ready high.
// Let Q = max(CHANNEL_BITS, 9). While the receiver keeps out_px.ready high,
// one pixel is accepted every cycle: a front stage finds max, min and
// the hue sector, then a row of Q identical divider cells each settles one
// quotient bit of both divisions and passes the partial result to its neighbor.
// Every stage holds its own valid bit, so bubbles collapse and a new pixel
// enters as long as any stage downstream can move. When the receiver stalls,
// the last cell holds its result and the row fills up behind it; in_px.ready
// falls only once every stage is occupied.
// The synchronous reset clears all valid bits; the datapath holds no state
// between pixels.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::DEFAULT_CHANNEL_BITS
) (
  input logic           clk,
  input logic           rst_n,
  rgbhsv_pix_if.sink    in_px,
  rgbhsv_hsv_if.source  out_px
);

  localparam int CB = CHANNEL_BITS;
  localparam int HB = rgbhsv_pkg::HUE_BITS;
  localparam int QB = rgbhsv_pkg::quot_bits(CHANNEL_BITS);
  localparam int NW = CB + QB;

  // Index 0 is the front stage output, index k+1 the output of cell k.
  logic          stg_valid [0:QB];
  logic          stg_ready [0:QB];
  logic [NW-1:0] sat_rem   [0:QB];
  logic [CB-1:0] sat_div   [0:QB];
  logic [QB-1:0] sat_q     [0:QB];
  logic [NW-1:0] hue_rem   [0:QB];
  logic [CB-1:0] hue_div   [0:QB];
  logic [QB-1:0] hue_q     [0:QB];
  logic [CB-1:0] bright    [0:QB];

  rgbhsv_prep #(
    .CHANNEL_BITS (CB),
    .NUM_BITS     (NW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_px.valid),
    .up_ready (in_px.ready),
    .red      (in_px.red_in),
    .green    (in_px.green_in),
    .blue     (in_px.blue_in),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .sat_num  (sat_rem[0]),
    .sat_div  (sat_div[0]),
    .hue_num  (hue_rem[0]),
    .hue_div  (hue_div[0]),
    .bright   (bright[0])
  );

  // Quotients start empty and collect one bit per cell, most significant first.
  assign sat_q[0] = '0;
  assign hue_q[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rgbhsv_div_cell #(
      .CHANNEL_BITS (CB),
      .QUOT_BITS    (QB),
      .NUM_BITS     (NW),
      .BIT_POS      (QB - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (stg_valid[k]),
      .up_ready  (stg_ready[k]),
      .sat_rem_i (sat_rem[k]),
      .sat_div_i (sat_div[k]),
      .sat_q_i   (sat_q[k]),
      .hue_rem_i (hue_rem[k]),
      .hue_div_i (hue_div[k]),
      .hue_q_i   (hue_q[k]),
      .bright_i  (bright[k]),
      .dn_valid  (stg_valid[k+1]),
      .dn_ready  (stg_ready[k+1]),
      .sat_rem_o (sat_rem[k+1]),
      .sat_div_o (sat_div[k+1]),
      .sat_q_o   (sat_q[k+1]),
      .hue_rem_o (hue_rem[k+1]),
      .hue_div_o (hue_div[k+1]),
      .hue_q_o   (hue_q[k+1]),
      .bright_o  (bright[k+1])
    );
  end

  // The last cell's registers are the output register of the block. The
  // final remainders and divisors are not needed past the last cell.
  assign stg_ready[QB]     = out_px.ready;
  assign out_px.valid      = stg_valid[QB];
  assign out_px.hue_deg    = hue_q[QB][HB-1:0];
  assign out_px.saturation = sat_q[QB][CB-1:0];
  assign out_px.brightness = bright[QB];

  // Every hue leaving the block is a whole degree below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.valid |-> (out_px.hue_deg < HB'(rgbhsv_pkg::DEG_360)))
    else $error("hue out of range");

  // A black pixel has neither saturation nor hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && out_px.brightness == '0) |->
      (out_px.saturation == '0 && out_px.hue_deg == '0))
    else $error("black pixel with nonzero saturation or hue");

  // Zero saturation on a lit pixel means a grey pixel, whose hue is zero.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && out_px.brightness != '0 && out_px.saturation == '0) |->
      (out_px.hue_deg == '0))
    else $error("grey pixel with nonzero hue");

  // With the receiver ready the whole row moves, so the input must be open.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_px.ready |-> in_px.ready)
    else $error("input stalled while output is ready");

endmodule
